// File: sv/shma_pkg.sv
package shma_pkg;

    // History geometry and sample format
    localparam int HISTORY_DEPTH = 8;
    localparam int SAMPLE_WIDTH  = 24;
    localparam int STAMP_WIDTH   = 32;

    // Width of a clamped window length (1 .. HISTORY_DEPTH)
    localparam int WIN_W   = $clog2(HISTORY_DEPTH + 1);
    // Signed window sum never overflows this width
    localparam int SUM_W   = SAMPLE_WIDTH + $clog2(HISTORY_DEPTH);
    // Divider step counter holds 0 .. SUM_W
    localparam int DCNT_W  = $clog2(SUM_W + 1);
    // Compare width for clamping the window register against the depth
    localparam int CLAMP_W = 8;

    // Stream payload widths, rounded up to whole bytes
    localparam int TDATA_IN_W  = ((SAMPLE_WIDTH + STAMP_WIDTH + 7) / 8) * 8;
    localparam int TDATA_OUT_W = ((2 * SAMPLE_WIDTH + STAMP_WIDTH + 7) / 8) * 8;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOLEAN_MODE = 1'd1;

    localparam logic [CFG_DATA_W-1:0] WINDOW_LEN_RST = 4'd8;

    typedef logic signed [SAMPLE_WIDTH-1:0] t_sample;
    typedef logic        [SUM_W-1:0]        t_mag;

endpackage

// File: sv/shma_cell.sv
module shma_cell
    import shma_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_shift,
    input  t_sample i_d,
    output t_sample o_q
);

    t_sample r_q;

    // Take the neighbor's entry on every shift; history starts at zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

// File: sv/shma_div.sv
module shma_div
    import shma_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  t_mag             i_dividend,
    input  logic [WIN_W-1:0] i_divisor,
    output logic             o_done,
    output t_mag             o_quot
);

    logic              r_busy;
    logic              r_done;
    logic [DCNT_W-1:0] r_cnt;
    logic [WIN_W-1:0]  r_rem;
    logic [WIN_W-1:0]  r_den;
    t_mag              r_quot;

    logic [WIN_W:0]    trial;
    logic [WIN_W:0]    diff;
    logic              fits;

    // One restoring step: bring down the next dividend bit
    assign trial = {r_rem, r_quot[SUM_W-1]};
    assign diff  = trial - {1'b0, r_den};
    assign fits  = trial >= {1'b0, r_den};

    // Control: count SUM_W steps, flag the last one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DCNT_W'(SUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: quotient bits shift in where dividend bits shift out
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_den  <= i_divisor;
        end else if (r_busy) begin
            r_rem  <= fits ? diff[WIN_W-1:0] : trial[WIN_W-1:0];
            r_quot <= {r_quot[SUM_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// File: sv/sample_history_moving_average_top.sv
// Moving average over a sample history. Each input beat carries a signed
// sample (8 fractional bits) and a timestamp; the sample enters a history of
// HISTORY_DEPTH entries (zero after reset), and one output beat returns the
// sample, the mean of the newest window_len entries truncated toward zero
// (entries still zero from reset count), and the timestamp. window_len is
// clamped to 1 .. HISTORY_DEPTH; in boolean mode the mean is the sample. An
// item's time in the block is set by one full rotation of the history ring
// to form the sum and a one-bit-per-cycle divide; boolean mode skips both.
// One item is worked on at a time; a finished beat waits in the output
// register while the next item is accepted.
module sample_history_moving_average_top
    import shma_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // config write port
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    // input stream
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [TDATA_IN_W-1:0]  i_s_axis_tdata,  // sample, stamp
    // output stream
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [TDATA_OUT_W-1:0] o_m_axis_tdata   // latest_value, mean_value, latest_stamp
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SUM  = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [CFG_DATA_W-1:0] r_window_len;
    logic                  r_boolean_mode;

    logic [WIN_W-1:0]       r_cnt;
    logic signed [SUM_W-1:0] r_acc;
    logic                   r_div_start;
    logic                   r_neg;
    t_sample                r_sample;
    logic [STAMP_WIDTH-1:0] r_stamp;
    t_sample                r_mean;

    logic                   r_out_valid;
    t_sample                r_out_latest;
    t_sample                r_out_mean;
    logic [STAMP_WIDTH-1:0] r_out_stamp;

    logic             in_beat;
    logic             out_free;
    logic             last_rot;
    logic [WIN_W-1:0] win;
    logic             take;
    logic             shift;
    t_sample          head_d;
    t_sample          cell_q [HISTORY_DEPTH];
    t_sample          tail;
    t_mag             mag;
    logic             div_done;
    t_mag             quot;
    t_sample          q_s;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_beat  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_out_valid || i_m_axis_tready;
    assign last_rot = (r_cnt == WIN_W'(HISTORY_DEPTH - 1));

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_len   <= WINDOW_LEN_RST;
            r_boolean_mode <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WINDOW_LEN:   r_window_len   <= i_cfg_data;
                CFG_BOOLEAN_MODE: r_boolean_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Clamp window to 1 .. HISTORY_DEPTH
    always_comb begin
        if (r_window_len == '0) begin
            win = WIN_W'(1);
        end else if (CLAMP_W'(r_window_len) > CLAMP_W'(HISTORY_DEPTH)) begin
            win = WIN_W'(HISTORY_DEPTH);
        end else begin
            win = WIN_W'(r_window_len);
        end
    end

    // History ring: shift in on accept, rotate once around while summing
    assign tail   = cell_q[HISTORY_DEPTH-1];
    assign shift  = in_beat || (r_state == S_SUM);
    assign head_d = (r_state == S_SUM) ? tail : i_s_axis_tdata[SAMPLE_WIDTH-1:0];

    for (genvar k = 0; k < HISTORY_DEPTH; k++) begin : g_cell
        shma_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (shift),
            .i_d     ((k == 0) ? head_d : cell_q[(k == 0) ? 0 : k - 1]),
            .o_q     (cell_q[k])
        );
    end

    // Tail shows the oldest entry first; add only the newest win entries
    assign take = ({1'b0, r_cnt} + {1'b0, win}) >= (WIN_W + 1)'(HISTORY_DEPTH);

    // Divide magnitude, fix the sign afterwards
    assign mag = r_acc[SUM_W-1] ? t_mag'(-r_acc) : t_mag'(r_acc);

    shma_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (mag),
        .i_divisor  (win),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    assign q_s = quot[SAMPLE_WIDTH-1:0];

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (in_beat) n_state = r_boolean_mode ? S_DONE : S_SUM;
            S_SUM:  if (last_rot) n_state = S_DIV;
            S_DIV:  if (div_done) n_state = S_DONE;
            S_DONE: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_div_start <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_div_start <= (r_state == S_SUM) && last_rot;
        end
    end

    // Item datapath: capture beat, accumulate, finish mean
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_sample <= i_s_axis_tdata[SAMPLE_WIDTH-1:0];
            r_stamp  <= i_s_axis_tdata[SAMPLE_WIDTH +: STAMP_WIDTH];
            r_mean   <= i_s_axis_tdata[SAMPLE_WIDTH-1:0];
            r_cnt    <= '0;
            r_acc    <= '0;
        end else if (r_state == S_SUM) begin
            r_cnt <= r_cnt + 1'b1;
            if (take) begin
                r_acc <= r_acc + SUM_W'(tail);
            end
        end
        if (r_div_start) begin
            r_neg <= r_acc[SUM_W-1];
        end
        if ((r_state == S_DIV) && div_done) begin
            r_mean <= r_neg ? -q_s : q_s;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_DONE) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && out_free) begin
            r_out_latest <= r_sample;
            r_out_mean   <= r_mean;
            r_out_stamp  <= r_stamp;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = TDATA_OUT_W'({r_out_stamp, r_out_mean, r_out_latest});

endmodule

// File: dv/sample_history_moving_average_top_tb.sv
module sample_history_moving_average_top_tb
    import shma_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET = 1550;
    localparam int LONG_HOLD   = 400;
    localparam int DRAIN_WAIT  = HISTORY_DEPTH + SUM_W + 40;

    typedef struct packed {
        logic [STAMP_WIDTH-1:0] stamp;
        t_sample                smp;
    } t_sensor_beat;

    typedef struct packed {
        logic [STAMP_WIDTH-1:0] stamp;
        t_sample                mean;
        t_sample                latest;
    } t_avg_result;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_BURSTY} t_rx_style;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx = CFG_WINDOW_LEN;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [TDATA_IN_W-1:0]  i_s_axis_tdata = '0;   // sample, stamp
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [TDATA_OUT_W-1:0] o_m_axis_tdata;        // latest_value, mean_value, latest_stamp

    sample_history_moving_average_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // Predictor state: history line and register shadows
    t_sample               hist_line [HISTORY_DEPTH];
    logic [CFG_DATA_W-1:0] win_reg  = WINDOW_LEN_RST;
    logic                  bool_reg = 1'b0;

    t_sensor_beat sensor_q [$];
    t_avg_result  avg_due_q [$];

    int      items_queued  = 0;
    int      items_taken   = 0;
    int      results_seen  = 0;
    int      errors        = 0;
    int      cfg_writes    = 0;
    int      bool_items    = 0;
    int      rx_hold_asks  = 0;
    bit [HISTORY_DEPTH:1] win_used = '0;
    bit      in_taken      = 1'b0;
    t_sample last_smp      = '0;

    // Clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Shift a sample into the history and form the expected window mean
    function automatic t_avg_result shift_and_average(t_sample smp, logic [STAMP_WIDTH-1:0] st);
        t_avg_result r;
        longint      sum;
        longint      n;
        for (int i = HISTORY_DEPTH - 1; i > 0; i--)
            hist_line[i] = hist_line[i-1];
        hist_line[0] = smp;
        r.latest = smp;
        r.stamp  = st;
        if (bool_reg) begin
            r.mean = smp;
            bool_items++;
        end else begin
            if (win_reg == '0)
                n = 1;
            else if (longint'(win_reg) > longint'(HISTORY_DEPTH))
                n = longint'(HISTORY_DEPTH);
            else
                n = longint'(win_reg);
            win_used[n] = 1'b1;
            sum = 0;
            for (int i = 0; i < n; i++)
                sum += longint'(hist_line[i]);
            // signed divide truncates toward zero
            r.mean = t_sample'(sum / n);
        end
        return r;
    endfunction

    // Input side: predict on every accepted beat
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            avg_due_q.push_back(shift_and_average(i_s_axis_tdata[SAMPLE_WIDTH-1:0],
                                i_s_axis_tdata[SAMPLE_WIDTH +: STAMP_WIDTH]));
            items_taken++;
            in_taken = 1'b1;
        end
    end

    // Output side: compare each accepted beat with the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_avg_result exp_r;
        t_avg_result act_r;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            act_r = o_m_axis_tdata[2*SAMPLE_WIDTH+STAMP_WIDTH-1:0];
            results_seen++;
            if (avg_due_q.size() == 0) begin
                $display("%0t: unexpected result beat latest=%0d mean=%0d stamp=%h",
                         $time, act_r.latest, act_r.mean, act_r.stamp);
                errors++;
            end else begin
                exp_r = avg_due_q.pop_front();
                if (act_r.latest !== exp_r.latest) begin
                    $display("%0t: latest_value expected %0d, got %0d",
                             $time, exp_r.latest, act_r.latest);
                    errors++;
                end
                if (act_r.mean !== exp_r.mean) begin
                    $display("%0t: mean_value expected %0d, got %0d",
                             $time, exp_r.mean, act_r.mean);
                    errors++;
                end
                if (act_r.stamp !== exp_r.stamp) begin
                    $display("%0t: latest_stamp expected %h, got %h",
                             $time, exp_r.stamp, act_r.stamp);
                    errors++;
                end
            end
        end
    end

    // Sender: bursts of beats with random gaps, fed from the sensor queue
    int burst_left = 0;
    int gap_left   = 0;
    always @(negedge i_clk) begin : sender
        logic                  nxt_valid;
        logic [TDATA_IN_W-1:0] nxt_data;
        t_sensor_beat          b;
        nxt_valid = i_s_axis_tvalid;
        nxt_data  = i_s_axis_tdata;
        if (i_rst_n && (!i_s_axis_tvalid || in_taken)) begin
            nxt_valid = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (sensor_q.size() > 0) begin
                b = sensor_q.pop_front();
                nxt_valid = 1'b1;
                nxt_data  = b;
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0) begin
                    // occasional long stretch without gaps
                    if ($urandom_range(0, 5) == 0) begin
                        gap_left   = 0;
                        burst_left = $urandom_range(20, 60);
                    end else begin
                        gap_left   = $urandom_range(1, 60);
                        burst_left = $urandom_range(1, 8);
                    end
                end
            end
        end
        in_taken = 1'b0;
        i_s_axis_tvalid <= nxt_valid;
        i_s_axis_tdata  <= nxt_data;
    end

    // Receiver: stall pattern of its own, plus long hold-offs on request
    t_rx_style rx_style      = RX_OPEN;
    int        rx_style_left = 0;
    int        rx_hold_left  = 0;
    int        rx_hold_seen  = 0;
    int        rx_tick       = 0;
    always @(negedge i_clk) begin : receiver
        logic rdy;
        if (rx_hold_seen != rx_hold_asks) begin
            rx_hold_seen = rx_hold_asks;
            rx_hold_left = LONG_HOLD;
        end
        rx_tick++;
        if (rx_hold_left > 0) begin
            rdy = 1'b0;
            rx_hold_left--;
        end else begin
            if (rx_style_left == 0) begin
                rx_style      = t_rx_style'($urandom_range(0, 3));
                rx_style_left = $urandom_range(20, 300);
            end
            rx_style_left--;
            case (rx_style)
                RX_OPEN:   rdy = 1'b1;
                RX_COIN:   rdy = 1'($urandom_range(0, 1));
                RX_SPARSE: rdy = ($urandom_range(0, 3) == 0);
                default:   rdy = rx_tick[3];
            endcase
        end
        i_m_axis_tready <= rdy;
    end

    // Write one register while the block is idle, shadow it in the predictor
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        if (idx == CFG_WINDOW_LEN)
            win_reg = val;
        else
            bool_reg = val[0];
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic queue_beat(t_sample smp, logic [STAMP_WIDTH-1:0] st);
        t_sensor_beat b;
        b.smp   = smp;
        b.stamp = st;
        sensor_q.push_back(b);
        items_queued++;
    endtask

    // Wait until every queued beat has been taken and has produced its result
    task automatic drain;
        while (items_taken != items_queued || avg_due_q.size() != 0)
            @(negedge i_clk);
    endtask

    function automatic t_sample pick_sample();
        t_sample s;
        case ($urandom_range(0, 11))
            0:       s = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
            1:       s = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
            2:       s = t_sample'($urandom_range(0, 2047)) - t_sample'(1024);
            3:       s = $urandom_range(0, 1) ? t_sample'(1) : t_sample'(-1);
            4, 5:    s = last_smp;
            6:       s = -last_smp;
            default: s = t_sample'($urandom);
        endcase
        last_smp = s;
        return s;
    endfunction

    function automatic logic [STAMP_WIDTH-1:0] pick_stamp();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    localparam t_sample SMP_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam t_sample SMP_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    // Main sequence
    initial begin : main_seq
        int             fixed_wins [4];
        int             phase;
        int             n_items;
        int             base_taken;
        logic [3:0]     bool_data;
        logic           want_bool;
        fixed_wins = '{0, 15, 1, HISTORY_DEPTH};
        for (int i = 0; i < HISTORY_DEPTH; i++)
            hist_line[i] = '0;

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Extremes with the reset window, history still filling with zeros
        queue_beat(SMP_MAX, '0);
        queue_beat(SMP_MAX, '1);
        queue_beat(SMP_MIN, 32'd1);
        queue_beat(t_sample'(-1), 32'h8000_0000);
        queue_beat('0, 32'h7fff_ffff);
        queue_beat(t_sample'(1), 32'h5555_aaaa);
        drain();

        // Window of one, then a zero window that clamps to one
        write_reg(CFG_WINDOW_LEN, 4'd1);
        queue_beat(SMP_MIN, 32'h0000_ffff);
        queue_beat(SMP_MAX, 32'hffff_0000);
        drain();
        write_reg(CFG_WINDOW_LEN, 4'd0);
        queue_beat(t_sample'(-1), 32'h1234_5678);
        queue_beat(t_sample'(24'h123456), 32'h8765_4321);
        drain();

        // Oversized window saturates to the full depth; fill with the minimum
        write_reg(CFG_WINDOW_LEN, 4'd15);
        for (int i = 0; i < HISTORY_DEPTH; i++)
            queue_beat(SMP_MIN, 32'(i));
        drain();
        write_reg(CFG_WINDOW_LEN, 4'd9);
        queue_beat(t_sample'(-3), 32'hdead_beef);
        drain();

        // Boolean mode still shifts history; upper data bits are ignored
        write_reg(CFG_BOOLEAN_MODE, 4'b0001);
        queue_beat(t_sample'(-7), 32'h0bad_cafe);
        queue_beat(SMP_MAX, 32'h0000_0001);
        drain();
        write_reg(CFG_BOOLEAN_MODE, 4'b1110);
        queue_beat(t_sample'(5), 32'hfffe_0001);
        drain();

        // Random phases, register settings changed only between them
        phase = 0;
        while (items_queued < ITEM_TARGET) begin
            want_bool = (phase == 2) || ($urandom_range(0, 4) == 0 && phase > 4);
            bool_data = {3'($urandom_range(0, 7)), want_bool};
            write_reg(CFG_BOOLEAN_MODE, bool_data);
            write_reg(CFG_WINDOW_LEN,
                      (phase < 4) ? 4'(fixed_wins[phase]) : 4'($urandom_range(0, 15)));
            n_items = $urandom_range(60, 140);
            base_taken = items_taken;
            for (int i = 0; i < n_items; i++)
                queue_beat(pick_sample(), pick_stamp());
            // Long receiver hold-off while the sender keeps offering beats
            if (phase == 1 || phase == 7) begin
                while (items_taken < base_taken + 5)
                    @(negedge i_clk);
                rx_hold_asks++;
            end
            drain();
            phase++;
        end

        repeat (DRAIN_WAIT) @(posedge i_clk);
        $display("Covered %0d sensor beats, %0d result beats, %0d register writes over %0d phases",
                 items_taken, results_seen, cfg_writes, phase);
        $display("Averaged windows (bit n = window n): %b, boolean-mode beats: %0d",
                 win_used, bool_items);
        if (errors == 0 && avg_due_q.size() == 0)
            $display("sample_history_moving_average_top_tb: PASS");
        else
            $display("sample_history_moving_average_top_tb: FAIL");
        $finish;
    end

    // Watchdog
    initial begin
        #3ms;
        $display("Timeout with %0d beats still awaited", avg_due_q.size());
        $display("sample_history_moving_average_top_tb: FAIL");
        $finish;
    end

endmodule
